@@ design/lgfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lgfp_pkg
// Shared constants, codes and types of the LED grayscale frame packer.
// ----------------------------------------------------------------------------
package lgfp_pkg;

  // Fixed geometry of the driver chain
  localparam int CHANNELS      = 48;
  localparam int WORD_BITS     = 48;
  localparam int GRAY_W        = 16;
  localparam int GRAY_BITS_DEF = 16;
  localparam int CHAN_IDX_W    = 6;

  // Request and result field widths
  localparam int MODE_W    = 3;
  localparam int CHANNEL_W = 8;
  localparam int EDGES_W   = 6;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FC    = 3'd4;

  // Result kinds
  localparam logic KIND_WIRE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_BITPLANE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_GS_EDGES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_WORD_EDGES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FC_UNLOCK_EDGES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FC_WRITE_EDGES  = 3'd4;

  // Configuration reset values
  localparam logic [EDGES_W-1:0] WRITE_GS_EDGES_RST  = 6'd1;
  localparam logic [EDGES_W-1:0] LAST_WORD_EDGES_RST = 6'd3;
  localparam logic [EDGES_W-1:0] FC_UNLOCK_EDGES_RST = 6'd15;
  localparam logic [EDGES_W-1:0] FC_WRITE_EDGES_RST  = 6'd5;

  // Output word sources
  localparam logic [1:0] SRC_READ   = 2'd0;
  localparam logic [1:0] SRC_GS     = 2'd1;
  localparam logic [1:0] SRC_UNLOCK = 2'd2;
  localparam logic [1:0] SRC_FC     = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       wr_chan;
    logic       clear;
    logic       load_fc;
    logic       emit;
    logic [1:0] src;
    logic       last;
  } lgfp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } lgfp_stat_t;

  // A latch count beyond one word never raises the latch inside it
  function automatic logic [EDGES_W-1:0] lat_count(input logic [EDGES_W-1:0] n);
    return (n > EDGES_W'(WORD_BITS)) ? '0 : n;
  endfunction

endpackage

@@ design/lgfp_in_if.sv @@
// ----------------------------------------------------------------------------
// lgfp_in_if
// Request channel of the frame packer: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface lgfp_in_if import lgfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CHANNEL_W-1:0] channel;
  logic [GRAY_W-1:0]    value;
  logic [WORD_BITS-1:0] fc_word;

  modport source (output valid, mode, channel, value, fc_word, input ready);
  modport sink   (input valid, mode, channel, value, fc_word, output ready);
endinterface

@@ design/lgfp_out_if.sv @@
// ----------------------------------------------------------------------------
// lgfp_out_if
// Result channel of the frame packer: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface lgfp_out_if import lgfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [WORD_BITS-1:0] wire_word;
  logic [EDGES_W-1:0]   lat_edges;
  logic                 last;
  logic [GRAY_W-1:0]    read_value;

  modport source (output valid, kind, wire_word, lat_edges, last, read_value,
                  input ready);
  modport sink   (input valid, kind, wire_word, lat_edges, last, read_value,
                  output ready);
endinterface

@@ design/lgfp_datapath.sv @@
// ----------------------------------------------------------------------------
// lgfp_datapath
// Grayscale shadow registers, configuration, word packing and output register.
// ----------------------------------------------------------------------------
module lgfp_datapath import lgfp_pkg::*; #(
  parameter int GRAY_BITS = GRAY_BITS_DEF,
  parameter int PLANE_W   = (GRAY_BITS > 1) ? $clog2(GRAY_BITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // command and status
  input  lgfp_cmd_t             cmd,
  input  logic [PLANE_W-1:0]    plane,
  output lgfp_stat_t            stat,
  // request payload
  input  logic [CHANNEL_W-1:0]  channel,
  input  logic [GRAY_W-1:0]     value,
  input  logic [WORD_BITS-1:0]  fc_word,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [WORD_BITS-1:0]  wire_word,
  output logic [EDGES_W-1:0]    lat_edges,
  output logic                  last,
  output logic [GRAY_W-1:0]     read_value
);

  localparam int IMG_BITS = CHANNELS * GRAY_BITS;

  logic [GRAY_W-1:0]    shadow [CHANNELS];
  logic                 layout_bitplane;
  logic [EDGES_W-1:0]   write_gs_edges;
  logic [EDGES_W-1:0]   last_word_edges;
  logic [EDGES_W-1:0]   fc_unlock_edges;
  logic [EDGES_W-1:0]   fc_write_edges;
  logic [WORD_BITS-1:0] fc_hold;

  logic                 chan_ok;
  logic [GRAY_W-1:0]    rd_data;
  logic [IMG_BITS-1:0]  image;
  logic [WORD_BITS-1:0] plane_word;
  logic [WORD_BITS-1:0] chan_word;
  logic [WORD_BITS-1:0] gs_word;

  assign chan_ok       = channel < CHANNEL_W'(CHANNELS);
  assign stat.out_free = !out_valid || out_ready;

  // Hold the grayscale shadow; clear on reset or on request
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int c = 0; c < CHANNELS; c++) shadow[c] <= '0;
    end else if (cmd.wr_chan && chan_ok) begin
      shadow[channel[CHAN_IDX_W-1:0]] <= value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_bitplane <= 1'b0;
      write_gs_edges  <= WRITE_GS_EDGES_RST;
      last_word_edges <= LAST_WORD_EDGES_RST;
      fc_unlock_edges <= FC_UNLOCK_EDGES_RST;
      fc_write_edges  <= FC_WRITE_EDGES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYOUT_BITPLANE: layout_bitplane <= cfg_data[0];
        REG_WRITE_GS_EDGES:  write_gs_edges  <= cfg_data;
        REG_LAST_WORD_EDGES: last_word_edges <= cfg_data;
        REG_FC_UNLOCK_EDGES: fc_unlock_edges <= cfg_data;
        REG_FC_WRITE_EDGES:  fc_write_edges  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the function control word for the second result
  always_ff @(posedge clk) begin
    if (cmd.load_fc) begin
      fc_hold <= fc_word;
    end
  end

  // Readback of one channel, zero when out of range
  assign rd_data = chan_ok ? shadow[channel[CHAN_IDX_W-1:0]] : '0;

  // Pack the low grayscale bits, highest channel in the top bits
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      image[c*GRAY_BITS +: GRAY_BITS] = shadow[c][GRAY_BITS-1:0];
    end
  end

  // Gather one bit weight across all channels, or one slice of the stream
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      plane_word[c] = image[c*GRAY_BITS + int'(plane)];
    end
    chan_word = image[WORD_BITS*int'(plane) +: WORD_BITS];
    gs_word   = layout_bitplane ? plane_word : chan_word;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      case (cmd.src)
        SRC_READ: begin
          kind       <= KIND_READ;
          wire_word  <= '0;
          lat_edges  <= '0;
          read_value <= rd_data;
        end
        SRC_GS: begin
          kind       <= KIND_WIRE;
          wire_word  <= gs_word;
          lat_edges  <= cmd.last ? lat_count(last_word_edges) : lat_count(write_gs_edges);
          read_value <= '0;
        end
        SRC_UNLOCK: begin
          kind       <= KIND_WIRE;
          wire_word  <= '0;
          lat_edges  <= lat_count(fc_unlock_edges);
          read_value <= '0;
        end
        default: begin
          kind       <= KIND_WIRE;
          wire_word  <= fc_hold;
          lat_edges  <= lat_count(fc_write_edges);
          read_value <= '0;
        end
      endcase
    end
  end

endmodule

@@ design/lgfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgfp_ctrl
// Request sequencer: decodes the mode and steps through flush and
// function control words, one word per free output slot.
// ----------------------------------------------------------------------------
module lgfp_ctrl import lgfp_pkg::*; #(
  parameter int GRAY_BITS = GRAY_BITS_DEF,
  parameter int PLANE_W   = (GRAY_BITS > 1) ? $clog2(GRAY_BITS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  lgfp_stat_t         stat,
  output lgfp_cmd_t          cmd,
  output logic [PLANE_W-1:0] plane
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_FC    = 2'd2;

  localparam logic [PLANE_W-1:0] PLANE_TOP  = PLANE_W'(GRAY_BITS - 1);
  localparam logic [PLANE_W-1:0] PLANE_NEXT = PLANE_W'(GRAY_BITS - 2);

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [PLANE_W-1:0] cnt;
  logic [PLANE_W-1:0] cnt_next;
  logic               accept;

  assign in_ready = (state == ST_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  // Decode requests and sequence multi-word results
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.src     = SRC_READ;
    plane       = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_SET:   cmd.wr_chan = 1'b1;
            MODE_CLEAR: cmd.clear   = 1'b1;
            MODE_READ: begin
              cmd.emit = 1'b1;
              cmd.src  = SRC_READ;
              cmd.last = 1'b1;
            end
            MODE_FLUSH: begin
              cmd.emit = 1'b1;
              cmd.src  = SRC_GS;
              plane    = PLANE_TOP;
              if (GRAY_BITS == 1) begin
                cmd.last = 1'b1;
              end else begin
                state_next = ST_FLUSH;
                cnt_next   = PLANE_NEXT;
              end
            end
            MODE_FC: begin
              cmd.emit    = 1'b1;
              cmd.src     = SRC_UNLOCK;
              cmd.load_fc = 1'b1;
              state_next  = ST_FC;
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_GS;
          cmd.last = (cnt == '0);
          if (cnt == '0) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      ST_FC: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_FC;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance state and word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Busy sequencing never takes a new request
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("request taken while sequencing");

  // A word is only loaded into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result register overwritten");

  // The final flush word returns the sequencer to idle
  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && cnt == '0 && stat.out_free) |=> (state == ST_IDLE))
    else $error("flush did not finish after final word");

endmodule

@@ design/led_grayscale_frame_packer_core.sv @@
// ----------------------------------------------------------------------------
// led_grayscale_frame_packer_core
// Grayscale shadow and wire-word packer for a chain of 48-channel LED drivers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests (valid/ready): set channel, read channel, clear,
//   flush and write function control. out_ch carries results (valid/ready):
//   48-bit wire words with their latch edge count, or a channel readback.
//   The cfg_we/cfg_index/cfg_data port writes the layout and latch counts;
//   write it only while no request is in progress.
// Timing:
//   A request is taken when the sequencer is idle and the result register is
//   free or being emptied. Set and clear give no result. A read gives one
//   result, a flush GRAY_BITS words and function control an unlock word then
//   the control word; the first result appears in the cycle after acceptance
//   and later words follow one per cycle while the receiver takes them. Each flush
//   word gathers one bit from every shadow register or one slice of the packed
//   stream. No new request is taken before the final word is registered.
// Reset clears the shadow, restores the register defaults and empties the
// result register. A stalled receiver holds the result and pauses the words.
// ----------------------------------------------------------------------------
module led_grayscale_frame_packer_core import lgfp_pkg::*; #(
  parameter int GRAY_BITS = GRAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lgfp_in_if.sink               in_ch,
  lgfp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PLANE_W = (GRAY_BITS > 1) ? $clog2(GRAY_BITS) : 1;

  lgfp_cmd_t          cmd;
  lgfp_stat_t         stat;
  logic [PLANE_W-1:0] plane;

  // Request sequencer
  lgfp_ctrl #(
    .GRAY_BITS (GRAY_BITS),
    .PLANE_W   (PLANE_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .mode     (in_ch.mode),
    .stat     (stat),
    .cmd      (cmd),
    .plane    (plane)
  );

  // Shadow, packing and result register
  lgfp_datapath #(
    .GRAY_BITS (GRAY_BITS),
    .PLANE_W   (PLANE_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .plane      (plane),
    .stat       (stat),
    .channel    (in_ch.channel),
    .value      (in_ch.value),
    .fc_word    (in_ch.fc_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .kind       (out_ch.kind),
    .wire_word  (out_ch.wire_word),
    .lat_edges  (out_ch.lat_edges),
    .last       (out_ch.last),
    .read_value (out_ch.read_value)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED grayscale frame packer: a burst-driven
// request source, a stalling result sink and a bit-exact mirror of the
// shadow, which packs the expected wire words and readbacks per request.
// ----------------------------------------------------------------------------
module testbench;
  import lgfp_pkg::*;

  localparam int FLUSH_WORDS = (CHANNELS * GRAY_BITS_DEF) / WORD_BITS;
  localparam int STREAM_W    = CHANNELS * GRAY_W;
  localparam int PHASE_ITEMS = 27;
  localparam int SETTLE_CYC  = 4;
  localparam int HOLD_CYC    = 300;
  localparam int MAX_REPORTS = 10;

  // Mode codes with no meaning; the block must drop them
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  // Receiver stall patterns
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_COIN     = 1;
  localparam int RDY_SPARSE   = 2;
  localparam int RDY_PERIODIC = 3;

  typedef struct {
    logic [MODE_W-1:0]    mode;
    logic [CHANNEL_W-1:0] channel;
    logic [GRAY_W-1:0]    value;
    logic [WORD_BITS-1:0] fc_word;
  } gs_req_t;

  typedef struct {
    logic                 kind;
    logic [WORD_BITS-1:0] wire_word;
    logic [EDGES_W-1:0]   lat_edges;
    logic                 last;
    logic [GRAY_W-1:0]    read_value;
  } gs_res_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lgfp_in_if  req_if ();
  lgfp_out_if res_if ();

  led_grayscale_frame_packer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block state
  logic [GRAY_W-1:0]  shadow_mirror [CHANNELS];
  logic               layout_bp;
  logic [EDGES_W-1:0] gs_edges;
  logic [EDGES_W-1:0] final_edges;
  logic [EDGES_W-1:0] unlock_edges;
  logic [EDGES_W-1:0] fcw_edges;

  gs_req_t req_queue [$];
  gs_res_t owed_results [$];

  gs_req_t drive_req;
  gs_req_t seen_req;
  gs_res_t seen_res;
  gs_res_t want_res;
  logic    req_taken = 1'b0;
  int      gap_left = 0;
  int      burst_left = 1;
  int      err_count = 0;
  logic    hold_armed = 1'b0;
  logic    hold_done = 1'b0;
  int      hold_left = 0;
  int      rdy_style = RDY_ALWAYS;
  int      style_left = 0;
  int      rdy_tick = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // A count beyond one word never raises the latch inside it
  function automatic logic [EDGES_W-1:0] clip_edges(input logic [EDGES_W-1:0] n);
    return (n > EDGES_W'(WORD_BITS)) ? '0 : n;
  endfunction

  // Gather wire word k of the grayscale image from the mirror
  function automatic logic [WORD_BITS-1:0] pack_flush_word(input int k);
    logic [STREAM_W-1:0]  stream;
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      stream[ch*GRAY_W +: GRAY_W] = shadow_mirror[ch];
    end
    if (layout_bp) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        w[ch] = shadow_mirror[ch][GRAY_W-1-k];
      end
    end else begin
      w = stream[STREAM_W-1-WORD_BITS*k -: WORD_BITS];
    end
    return w;
  endfunction

  // Update the mirror and queue the results owed for one accepted request
  task automatic apply_request(input gs_req_t r);
    gs_res_t res;
    res.kind       = KIND_WIRE;
    res.wire_word  = '0;
    res.lat_edges  = '0;
    res.last       = 1'b0;
    res.read_value = '0;
    case (r.mode)
      MODE_SET: begin
        if (r.channel < CHANNELS) shadow_mirror[r.channel[CHAN_IDX_W-1:0]] = r.value;
      end
      MODE_READ: begin
        res.kind       = KIND_READ;
        res.last       = 1'b1;
        res.read_value = (r.channel < CHANNELS) ?
                         shadow_mirror[r.channel[CHAN_IDX_W-1:0]] : '0;
        owed_results.push_back(res);
      end
      MODE_CLEAR: begin
        for (int ch = 0; ch < CHANNELS; ch++) shadow_mirror[ch] = '0;
      end
      MODE_FLUSH: begin
        for (int k = 0; k < FLUSH_WORDS; k++) begin
          res.wire_word = pack_flush_word(k);
          res.last      = (k == FLUSH_WORDS - 1);
          res.lat_edges = clip_edges(res.last ? final_edges : gs_edges);
          owed_results.push_back(res);
        end
      end
      MODE_FC: begin
        res.lat_edges = clip_edges(unlock_edges);
        owed_results.push_back(res);
        res.wire_word = r.fc_word;
        res.lat_edges = clip_edges(fcw_edges);
        res.last      = 1'b1;
        owed_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic note_error(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%t  %s", $realtime, what);
  endtask

  // Sample both channels: mirror accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        seen_req.mode    = req_if.mode;
        seen_req.channel = req_if.channel;
        seen_req.value   = req_if.value;
        seen_req.fc_word = req_if.fc_word;
        apply_request(seen_req);
      end
      if (res_if.valid && res_if.ready) begin
        seen_res.kind       = res_if.kind;
        seen_res.wire_word  = res_if.wire_word;
        seen_res.lat_edges  = res_if.lat_edges;
        seen_res.last       = res_if.last;
        seen_res.read_value = res_if.read_value;
        if (owed_results.size() == 0) begin
          note_error($sformatf("unexpected result kind=%0d word=%h lat=%0d last=%0d rd=%h",
                               seen_res.kind, seen_res.wire_word, seen_res.lat_edges,
                               seen_res.last, seen_res.read_value));
        end else begin
          want_res = owed_results.pop_front();
          if (seen_res.kind !== want_res.kind ||
              seen_res.wire_word !== want_res.wire_word ||
              seen_res.lat_edges !== want_res.lat_edges ||
              seen_res.last !== want_res.last ||
              seen_res.read_value !== want_res.read_value) begin
            note_error($sformatf({"mismatch exp kind=%0d word=%h lat=%0d last=%0d rd=%h",
                                  " got kind=%0d word=%h lat=%0d last=%0d rd=%h"},
                                 want_res.kind, want_res.wire_word, want_res.lat_edges,
                                 want_res.last, want_res.read_value,
                                 seen_res.kind, seen_res.wire_word, seen_res.lat_edges,
                                 seen_res.last, seen_res.read_value));
          end
        end
      end
    end
  end

  // Offer requests in bursts with random gaps; hold each until taken
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // hold the current request
    end else if (gap_left > 0) begin
      req_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (req_queue.size() > 0) begin
      drive_req = req_queue.pop_front();
      req_if.valid   <= 1'b1;
      req_if.mode    <= drive_req.mode;
      req_if.channel <= drive_req.channel;
      req_if.value   <= drive_req.value;
      req_if.fc_word <= drive_req.fc_word;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Stall the result side: rotating patterns plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      rdy_tick++;
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (style_left == 0) begin
        rdy_style  = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
        style_left = $urandom_range(20, 80);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (rdy_style)
          RDY_ALWAYS: res_if.ready <= 1'b1;
          RDY_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:    res_if.ready <= (rdy_tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic push_req(input logic [MODE_W-1:0] mode, input logic [CHANNEL_W-1:0] ch,
                          input logic [GRAY_W-1:0] val, input logic [WORD_BITS-1:0] fc);
    gs_req_t r;
    r.mode    = mode;
    r.channel = ch;
    r.value   = val;
    r.fc_word = fc;
    req_queue.push_back(r);
  endtask

  // Mostly channel writes, with flushes, reads, function control, clears and noise
  task automatic push_random_req();
    logic [63:0]          wide;
    logic [MODE_W-1:0]    mode;
    logic [CHANNEL_W-1:0] ch;
    logic [GRAY_W-1:0]    val;
    int                   pick;
    wide = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    ch   = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
    case ($urandom_range(0, 7))
      0:       val = '0;
      1:       val = '1;
      default: val = GRAY_W'($urandom);
    endcase
    if (pick < 50) begin
      mode = MODE_SET;
      if ($urandom_range(0, 9) == 0) ch = CHANNEL_W'($urandom_range(CHANNELS, 255));
    end else if (pick < 65) begin
      mode = MODE_READ;
      if ($urandom_range(0, 6) == 0) ch = CHANNEL_W'($urandom_range(0, 255));
    end else if (pick < 77) begin
      mode = MODE_FLUSH;
    end else if (pick < 85) begin
      mode = MODE_FC;
    end else if (pick < 90) begin
      mode = MODE_CLEAR;
    end else if (pick < 95) begin
      mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      ch   = CHANNEL_W'($urandom_range(0, 255));
    end else begin
      mode = MODE_SET;
      ch   = CHANNEL_W'($urandom_range(0, 255));
    end
    push_req(mode, ch, val, wide[WORD_BITS-1:0]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LAYOUT_BITPLANE: layout_bp    = data[0];
      REG_WRITE_GS_EDGES:  gs_edges     = data;
      REG_LAST_WORD_EDGES: final_edges  = data;
      REG_FC_UNLOCK_EDGES: unlock_edges = data;
      REG_FC_WRITE_EDGES:  fcw_edges    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] lay, input logic [CFG_DATA_W-1:0] gs,
                                input logic [CFG_DATA_W-1:0] fin, input logic [CFG_DATA_W-1:0] unl,
                                input logic [CFG_DATA_W-1:0] fcw);
    write_reg(REG_LAYOUT_BITPLANE, lay);
    write_reg(REG_WRITE_GS_EDGES, gs);
    write_reg(REG_LAST_WORD_EDGES, fin);
    write_reg(REG_FC_UNLOCK_EDGES, unl);
    write_reg(REG_FC_WRITE_EDGES, fcw);
  endtask

  // Drain: every request taken and every owed result seen, then settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((req_queue.size() != 0 || req_if.valid || owed_results.size() != 0) &&
           guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_SET;
    req_if.channel = '0;
    req_if.value   = '0;
    req_if.fc_word = '0;
    res_if.ready   = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) shadow_mirror[ch] = '0;
    layout_bp    = 1'b0;
    gs_edges     = WRITE_GS_EDGES_RST;
    final_edges  = LAST_WORD_EDGES_RST;
    unlock_edges = FC_UNLOCK_EDGES_RST;
    fcw_edges    = FC_WRITE_EDGES_RST;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, out-of-range channels, dead modes, every op
    push_req(MODE_SET, 8'd0, 16'hFFFF, '0);
    push_req(MODE_SET, 8'd47, 16'h8001, '1);
    push_req(MODE_SET, 8'd1, 16'h5A5A, '0);
    push_req(MODE_SET, 8'd48, 16'h1234, '0);
    push_req(MODE_SET, 8'd255, 16'hFFFF, '1);
    push_req(MODE_READ, 8'd0, '0, '0);
    push_req(MODE_READ, 8'd47, '0, '0);
    push_req(MODE_READ, 8'd48, '0, '0);
    push_req(MODE_READ, 8'd255, '1, '1);
    push_req(MODE_READ, 8'd2, '0, '0);
    push_req(MODE_SPARE_LO, 8'd0, 16'hAAAA, '1);
    push_req(MODE_SPARE_MID, 8'd3, 16'h5555, '0);
    push_req(MODE_SPARE_HI, 8'd255, 16'hFFFF, '1);
    push_req(MODE_READ, 8'd0, '0, '0);
    push_req(MODE_FLUSH, '0, '0, '0);
    push_req(MODE_FC, '0, '0, '1);
    push_req(MODE_FC, '0, '0, '0);
    push_req(MODE_FC, '0, '0, 48'hA5C3_0F1E_9B27);
    push_req(MODE_CLEAR, '0, '0, '0);
    push_req(MODE_READ, 8'd0, '0, '0);
    push_req(MODE_FLUSH, '0, '0, '0);
    push_req(MODE_SET, 8'd23, 16'h0001, '0);
    push_req(MODE_FLUSH, '0, '0, '0);
    wait_drained();

    // Random phases over several register settings, extremes first
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_all_regs(6'd1, 6'd0, 6'd48, 6'd49, 6'd63);
        1:       write_all_regs(6'd0, 6'd48, 6'd0, 6'd0, 6'd48);
        2:       write_all_regs(6'd1, 6'd63, 6'd1, 6'd48, 6'd0);
        default: write_all_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) push_random_req();
      // Long receiver hold-off while requests keep coming
      if (phase == 1) hold_armed = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (req_queue.size() != 0 || req_if.valid) begin
      note_error($sformatf("%0d requests never taken", req_queue.size()));
    end
    if (owed_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived", owed_results.size()));
    end
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lgfp_pkg.sv
design/lgfp_in_if.sv
design/lgfp_out_if.sv
design/lgfp_datapath.sv
design/lgfp_ctrl.sv
design/led_grayscale_frame_packer_core.sv
dv/testbench.sv
